FILE: sv/lgge_pkg.sv
// ----------------------------------------------------------------------------
// lgge_pkg
// Shared types and codes of the life grid generation engine: cell states,
// opcodes, configuration register indexes and the 3x3 neighborhood window.
// ----------------------------------------------------------------------------
package lgge_pkg;

    typedef logic [1:0] t_cell;
    typedef logic [2:0] t_opcode;
    typedef logic [5:0] t_row_index;
    typedef logic [6:0] t_column_index;
    typedef logic [1:0] t_cfg_index;
    typedef logic [7:0] t_cfg_data;

    localparam t_cell CELL_EMPTY  = 2'd0;
    localparam t_cell CELL_ALIVE  = 2'd1;
    localparam t_cell CELL_FORMER = 2'd2;
    localparam t_cell CELL_UNUSED = 2'd3;

    localparam t_opcode OP_WRITE   = 3'd0;
    localparam t_opcode OP_TOGGLE  = 3'd1;
    localparam t_opcode OP_READ    = 3'd2;
    localparam t_opcode OP_CLEAR   = 3'd3;
    localparam t_opcode OP_ADVANCE = 3'd4;

    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    localparam t_cfg_index REG_ACTIVE_ROWS    = 2'd0;
    localparam t_cfg_index REG_ACTIVE_COLUMNS = 2'd1;

    localparam logic [6:0] ACTIVE_ROWS_RESET    = 7'd40;
    localparam logic [7:0] ACTIVE_COLUMNS_RESET = 8'd70;

    localparam logic [3:0] NEIGHBORS_SURVIVE = 4'd2;
    localparam logic [3:0] NEIGHBORS_BIRTH   = 4'd3;

    typedef struct packed {
        t_cell top;
        t_cell mid;
        t_cell bot;
    } t_col3;

    typedef struct packed {
        t_col3 left;
        t_col3 center;
        t_col3 right;
    } t_window;

endpackage

FILE: sv/lgge_if.sv
// ----------------------------------------------------------------------------
// lgge channel interfaces
// Valid/ready channels of the engine: command items in, result items out,
// and the configuration register write channel.
// ----------------------------------------------------------------------------
interface lgge_cmd_if;
    logic                       valid;
    logic                       ready;
    lgge_pkg::t_opcode          opcode;
    lgge_pkg::t_row_index       row_index;
    lgge_pkg::t_column_index    column_index;
    lgge_pkg::t_cell            write_value;

    modport source (output valid, opcode, row_index, column_index, write_value, input ready);
    modport sink   (input valid, opcode, row_index, column_index, write_value, output ready);
endinterface

interface lgge_res_if;
    logic               valid;
    logic               ready;
    lgge_pkg::t_cell    cell_value;
    logic               status;

    modport source (output valid, cell_value, status, input ready);
    modport sink   (input valid, cell_value, status, output ready);
endinterface

interface lgge_cfg_if;
    logic                   valid;
    logic                   ready;
    lgge_pkg::t_cfg_index   index;
    lgge_pkg::t_cfg_data    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/life_grid_generation_engine_unit.sv
// ----------------------------------------------------------------------------
// life_grid_generation_engine_unit
// Three-state cellular automaton grid held in a single-port-read,
// single-port-write synchronous memory, with a two-row line buffer.
// ----------------------------------------------------------------------------
// One command item is in work at a time; the next may be accepted while the
// previous result still waits in the output register. Write, toggle and read
// register the address on accept, then pass through memory read, modify/write
// and result. An out-of-range coordinate or unused opcode goes from accept
// straight to the result. Clear grid sweeps the memory one entry per cycle
// over all MAX_ROWS * 2**clog2(MAX_COLUMNS) entries (8192 at the default
// size); the same sweep runs once after reset, during which no command is
// accepted. An advance streams the active area once through a three-stage
// pipeline, one cell per cycle, bounded by the single grid read port.
// Configuration writes are taken at any time, ready is always high.
// ----------------------------------------------------------------------------
module life_grid_generation_engine_unit #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lgge_cmd_if.sink   i_cmd,
    lgge_res_if.source o_res,
    lgge_cfg_if.sink   i_cfg
);

    localparam int RW         = $clog2(MAX_ROWS);
    localparam int CW         = $clog2(MAX_COLUMNS);
    localparam int AW         = RW + CW;
    localparam int GRID_DEPTH = MAX_ROWS * (2 ** CW);
    localparam int BUF_DEPTH  = 2 * (2 ** CW);
    localparam int KW         = $clog2(MAX_ROWS + 1);
    localparam int JW         = $clog2(MAX_COLUMNS + 1);
    localparam logic [8:0] MAX_ROWS_W    = 9'(MAX_ROWS);
    localparam logic [8:0] MAX_COLUMNS_W = 9'(MAX_COLUMNS);
    localparam logic [AW-1:0] CLR_LAST   = AW'(GRID_DEPTH - 1);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_CELL_RD = 3'd2;
    localparam logic [2:0] S_CELL_WR = 3'd3;
    localparam logic [2:0] S_ADV     = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]             r_state;
    logic [6:0]             r_active_rows;
    logic [7:0]             r_active_columns;
    logic [8:0]             eff_rows;
    logic [8:0]             eff_cols;

    logic [AW-1:0]          r_clr_addr;
    logic                   r_clr_reply;
    lgge_pkg::t_opcode      r_op;
    lgge_pkg::t_cell        r_wv;
    logic [AW-1:0]          r_addr;
    lgge_pkg::t_cell        r_res_value;
    logic                   r_res_status;
    logic                   r_out_valid;
    lgge_pkg::t_cell        r_out_value;
    logic                   r_out_status;

    logic [KW-1:0]          r_k;
    logic [JW-1:0]          r_j;
    logic                   r_issue;
    logic                   r_v1;
    logic [KW-1:0]          r_k1;
    logic [JW-1:0]          r_j1;
    logic                   r_v2;
    logic [KW-1:0]          r_k2;
    logic [JW-1:0]          r_j2;
    lgge_pkg::t_window      r_win;
    lgge_pkg::t_window      n_win;
    lgge_pkg::t_col3        n_col;

    lgge_pkg::t_cell        r_grid [GRID_DEPTH];
    lgge_pkg::t_cell        r_grid_q;
    lgge_pkg::t_cell        r_buf [BUF_DEPTH];
    lgge_pkg::t_cell        r_buf_top_q;
    lgge_pkg::t_cell        r_buf_mid_q;

    logic                   grid_re;
    logic                   grid_we;
    logic [AW-1:0]          grid_raddr;
    logic [AW-1:0]          grid_waddr;
    lgge_pkg::t_cell        grid_wdata;
    lgge_pkg::t_cell        cell_new;
    lgge_pkg::t_cell        rule_next;

    logic                   buf_re;
    logic                   buf_we;
    logic [CW:0]            buf_top_addr;
    logic [CW:0]            buf_mid_addr;
    logic [CW:0]            buf_waddr;

    logic                   cmd_accept;
    logic                   cmd_in_range;
    logic                   row_ok0;
    logic                   col_ok0;
    logic                   row_ok1;
    logic                   col_ok1;
    logic [KW-1:0]          k2_prev;
    logic [JW-1:0]          j2_prev;

    assign i_cfg.ready      = 1'b1;
    assign i_cmd.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.cell_value = r_out_value;
    assign o_res.status     = r_out_status;
    assign cmd_accept       = i_cmd.valid && i_cmd.ready;

    always_comb begin
        if (r_active_rows == 7'd0) begin
            eff_rows = 9'd1;
        end else if (9'(r_active_rows) > MAX_ROWS_W) begin
            eff_rows = MAX_ROWS_W;
        end else begin
            eff_rows = 9'(r_active_rows);
        end
        if (r_active_columns == 8'd0) begin
            eff_cols = 9'd1;
        end else if (9'(r_active_columns) > MAX_COLUMNS_W) begin
            eff_cols = MAX_COLUMNS_W;
        end else begin
            eff_cols = 9'(r_active_columns);
        end
    end

    assign cmd_in_range = (9'(i_cmd.row_index) < eff_rows)
                       && (9'(i_cmd.column_index) < eff_cols);
    assign row_ok0 = 9'(r_k) < eff_rows;
    assign col_ok0 = 9'(r_j) < eff_cols;
    assign row_ok1 = 9'(r_k1) < eff_rows;
    assign col_ok1 = 9'(r_j1) < eff_cols;
    assign k2_prev = r_k2 - KW'(1);
    assign j2_prev = r_j2 - JW'(1);

    assign buf_re       = (r_state == S_ADV) && r_issue;
    assign buf_top_addr = {r_k[0], r_j[CW-1:0]};
    assign buf_mid_addr = {~r_k[0], r_j[CW-1:0]};
    assign buf_we       = r_v1 && row_ok1 && col_ok1;
    assign buf_waddr    = {r_k1[0], r_j1[CW-1:0]};

    always_comb begin
        case (r_op)
            lgge_pkg::OP_WRITE: begin
                cell_new = (r_wv == lgge_pkg::CELL_UNUSED) ? lgge_pkg::CELL_EMPTY : r_wv;
            end
            lgge_pkg::OP_TOGGLE: begin
                cell_new = (r_grid_q == lgge_pkg::CELL_ALIVE)
                         ? lgge_pkg::CELL_EMPTY : lgge_pkg::CELL_ALIVE;
            end
            default: begin
                cell_new = r_grid_q;
            end
        endcase
    end

    always_comb begin
        grid_re    = 1'b0;
        grid_raddr = r_addr;
        grid_we    = 1'b0;
        grid_waddr = r_addr;
        grid_wdata = lgge_pkg::CELL_EMPTY;
        unique case (r_state)
            S_CLEAR: begin
                grid_we    = 1'b1;
                grid_waddr = r_clr_addr;
            end
            S_CELL_RD: begin
                grid_re = 1'b1;
            end
            S_CELL_WR: begin
                grid_we    = (r_op == lgge_pkg::OP_WRITE) || (r_op == lgge_pkg::OP_TOGGLE);
                grid_wdata = cell_new;
            end
            S_ADV: begin
                grid_re    = r_issue && row_ok0 && col_ok0;
                grid_raddr = {r_k[RW-1:0], r_j[CW-1:0]};
                grid_we    = r_v2 && (r_k2 != '0) && (r_j2 != '0);
                grid_waddr = {k2_prev[RW-1:0], j2_prev[CW-1:0]};
                grid_wdata = rule_next;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (grid_re) begin
            r_grid_q <= r_grid[grid_raddr];
        end
        if (grid_we) begin
            r_grid[grid_waddr] <= grid_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_re) begin
            r_buf_top_q <= r_buf[buf_top_addr];
            r_buf_mid_q <= r_buf[buf_mid_addr];
        end
        if (buf_we) begin
            r_buf[buf_waddr] <= r_grid_q;
        end
    end

    always_comb begin
        n_col.top = (r_k1 > KW'(1) && col_ok1) ? r_buf_top_q : lgge_pkg::CELL_EMPTY;
        n_col.mid = (r_k1 != '0 && col_ok1) ? r_buf_mid_q : lgge_pkg::CELL_EMPTY;
        n_col.bot = (row_ok1 && col_ok1) ? r_grid_q : lgge_pkg::CELL_EMPTY;
        if (r_j1 == '0) begin
            n_win.left   = '0;
            n_win.center = '0;
        end else begin
            n_win.left   = r_win.center;
            n_win.center = r_win.right;
        end
        n_win.right = n_col;
    end

    lgge_rule u_rule (
        .i_win  (r_win),
        .o_next (rule_next)
    );

    always_ff @(posedge i_clk) begin
        r_k1 <= r_k;
        r_j1 <= r_j;
        r_k2 <= r_k1;
        r_j2 <= r_j1;
        if (r_v1) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_CLEAR;
            r_clr_addr       <= '0;
            r_clr_reply      <= 1'b0;
            r_issue          <= 1'b0;
            r_v1             <= 1'b0;
            r_v2             <= 1'b0;
            r_out_valid      <= 1'b0;
            r_active_rows    <= lgge_pkg::ACTIVE_ROWS_RESET;
            r_active_columns <= lgge_pkg::ACTIVE_COLUMNS_RESET;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    lgge_pkg::REG_ACTIVE_ROWS:    r_active_rows    <= i_cfg.data[6:0];
                    lgge_pkg::REG_ACTIVE_COLUMNS: r_active_columns <= i_cfg.data;
                    default: begin
                    end
                endcase
            end

            r_v1 <= (r_state == S_ADV) && r_issue;
            r_v2 <= r_v1;

            if (o_res.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == CLR_LAST) begin
                        r_clr_addr   <= '0;
                        r_clr_reply  <= 1'b0;
                        r_res_value  <= lgge_pkg::CELL_EMPTY;
                        r_res_status <= lgge_pkg::STATUS_DONE;
                        r_state      <= r_clr_reply ? S_DONE : S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (cmd_accept) begin
                        r_op         <= i_cmd.opcode;
                        r_wv         <= i_cmd.write_value;
                        r_addr       <= {RW'(i_cmd.row_index), CW'(i_cmd.column_index)};
                        r_res_value  <= lgge_pkg::CELL_EMPTY;
                        case (i_cmd.opcode) inside
                            lgge_pkg::OP_WRITE, lgge_pkg::OP_TOGGLE, lgge_pkg::OP_READ: begin
                                if (cmd_in_range) begin
                                    r_res_status <= lgge_pkg::STATUS_DONE;
                                    r_state      <= S_CELL_RD;
                                end else begin
                                    r_res_status <= lgge_pkg::STATUS_RANGE;
                                    r_state      <= S_DONE;
                                end
                            end
                            lgge_pkg::OP_CLEAR: begin
                                r_clr_reply <= 1'b1;
                                r_state     <= S_CLEAR;
                            end
                            lgge_pkg::OP_ADVANCE: begin
                                r_k     <= '0;
                                r_j     <= '0;
                                r_issue <= 1'b1;
                                r_state <= S_ADV;
                            end
                            default: begin
                                r_res_status <= lgge_pkg::STATUS_DONE;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_CELL_RD: begin
                    r_state <= S_CELL_WR;
                end
                S_CELL_WR: begin
                    r_res_value  <= cell_new;
                    r_res_status <= lgge_pkg::STATUS_DONE;
                    r_state      <= S_DONE;
                end
                S_ADV: begin
                    if (r_issue) begin
                        if (9'(r_j) == eff_cols) begin
                            r_j <= '0;
                            if (9'(r_k) == eff_rows) begin
                                r_issue <= 1'b0;
                            end else begin
                                r_k <= r_k + KW'(1);
                            end
                        end else begin
                            r_j <= r_j + JW'(1);
                        end
                    end else if (!r_v1 && !r_v2) begin
                        r_res_value  <= lgge_pkg::CELL_EMPTY;
                        r_res_status <= lgge_pkg::STATUS_DONE;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_res_value;
                        r_out_status <= r_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the done state");

    a_pipe_in_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2) |-> (r_state == S_ADV))
        else $error("advance pipeline busy outside an advance");

    a_grid_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ADV) && grid_re && grid_we) |-> (grid_raddr != grid_waddr))
        else $error("advance writes the grid entry it reads");

    a_buf_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (buf_re && buf_we) |-> (buf_mid_addr != buf_waddr))
        else $error("line buffer written at the entry being read");

endmodule

FILE: sv/lgge_rule.sv
// ----------------------------------------------------------------------------
// lgge_rule
// Next state of the center cell of a 3x3 window: counts live neighbors and
// applies the birth and survival rule of the three-state automaton.
// ----------------------------------------------------------------------------
module lgge_rule (
    input  lgge_pkg::t_window i_win,
    output lgge_pkg::t_cell   o_next
);

    logic [3:0]      count;
    lgge_pkg::t_cell self_cell;

    always_comb begin
        self_cell = i_win.center.mid;
        count = 4'(i_win.left.top   == lgge_pkg::CELL_ALIVE)
              + 4'(i_win.left.mid   == lgge_pkg::CELL_ALIVE)
              + 4'(i_win.left.bot   == lgge_pkg::CELL_ALIVE)
              + 4'(i_win.center.top == lgge_pkg::CELL_ALIVE)
              + 4'(i_win.center.bot == lgge_pkg::CELL_ALIVE)
              + 4'(i_win.right.top  == lgge_pkg::CELL_ALIVE)
              + 4'(i_win.right.mid  == lgge_pkg::CELL_ALIVE)
              + 4'(i_win.right.bot  == lgge_pkg::CELL_ALIVE);
        if (self_cell == lgge_pkg::CELL_ALIVE) begin
            o_next = (count == lgge_pkg::NEIGHBORS_SURVIVE || count == lgge_pkg::NEIGHBORS_BIRTH)
                   ? lgge_pkg::CELL_ALIVE : lgge_pkg::CELL_FORMER;
        end else begin
            o_next = (count == lgge_pkg::NEIGHBORS_BIRTH) ? lgge_pkg::CELL_ALIVE : self_cell;
        end
    end

endmodule

FILE: tb/lgge_grid_predictor.sv
// ----------------------------------------------------------------------------
// lgge_grid_predictor
// Watches the command, result and register channels of the life grid engine.
// It keeps its own copy of the grid and of the active size, and works out the
// result of every accepted command. Each result is checked in order against
// the oldest prediction. The mismatch and outstanding counts go to the top.
// ----------------------------------------------------------------------------
module lgge_grid_predictor #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLUMNS = 128
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lgge_cmd_if  i_cmd,
    lgge_res_if  i_res,
    lgge_cfg_if  i_cfg,
    output int   o_mismatches,
    output int   o_outstanding,
    output int   o_checked,
    output int   o_advances,
    output int   o_flagged
);
    import lgge_pkg::*;

    typedef struct packed {
        t_cell cell_value;
        logic  status;
    } t_grid_result;

    t_cell        grid_now   [MAX_ROWS][MAX_COLUMNS];
    t_cell        grid_prior [MAX_ROWS][MAX_COLUMNS];
    logic [6:0]   rows_reg;
    logic [7:0]   cols_reg;
    t_grid_result pending_results [$];
    t_grid_result wanted;
    int           mismatches;
    int           outstanding;
    int           checked;
    int           advances;
    int           flagged;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;
    assign o_checked     = checked;
    assign o_advances    = advances;
    assign o_flagged     = flagged;

    function automatic int rows_in_use();
        if (rows_reg == 0) return 1;
        if (rows_reg > MAX_ROWS) return MAX_ROWS;
        return int'(rows_reg);
    endfunction

    function automatic int columns_in_use();
        if (cols_reg == 0) return 1;
        if (cols_reg > MAX_COLUMNS) return MAX_COLUMNS;
        return int'(cols_reg);
    endfunction

    function automatic void clear_grid();
        foreach (grid_now[r, c]) grid_now[r][c] = CELL_EMPTY;
    endfunction

    function automatic void step_generation();
        int nr;
        int nc;
        int count;
        int rr;
        int cc;
        int r;
        int c;
        int dr;
        int dc;
        nr = rows_in_use();
        nc = columns_in_use();
        grid_prior = grid_now;
        for (r = 0; r < nr; r++) begin
            for (c = 0; c < nc; c++) begin
                count = 0;
                for (dr = -1; dr <= 1; dr++) begin
                    for (dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && rr < nr && cc >= 0 && cc < nc
                                && grid_prior[rr][cc] == CELL_ALIVE) begin
                            count++;
                        end
                    end
                end
                if (grid_prior[r][c] == CELL_ALIVE) begin
                    if (count != NEIGHBORS_SURVIVE && count != NEIGHBORS_BIRTH) begin
                        grid_now[r][c] = CELL_FORMER;
                    end
                end else if (count == NEIGHBORS_BIRTH) begin
                    grid_now[r][c] = CELL_ALIVE;
                end
            end
        end
    endfunction

    function automatic t_grid_result apply_command(t_opcode op, t_row_index row,
                                                   t_column_index col, t_cell wv);
        t_grid_result res;
        res = '{cell_value: CELL_EMPTY, status: STATUS_DONE};
        case (op)
            OP_WRITE, OP_TOGGLE, OP_READ: begin
                if (row >= rows_in_use() || col >= columns_in_use()) begin
                    res.status = STATUS_RANGE;
                    flagged++;
                end else begin
                    if (op == OP_WRITE) begin
                        grid_now[row][col] = (wv == CELL_UNUSED) ? CELL_EMPTY : wv;
                    end else if (op == OP_TOGGLE) begin
                        grid_now[row][col] = (grid_now[row][col] == CELL_ALIVE) ?
                                             CELL_EMPTY : CELL_ALIVE;
                    end
                    res.cell_value = grid_now[row][col];
                end
            end
            OP_CLEAR: clear_grid();
            OP_ADVANCE: begin
                step_generation();
                advances++;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic note_mismatch(string what);
        mismatches++;
        if (mismatches <= 10) $display("lgge_grid_predictor: result %0d: %s", checked, what);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_grid();
            rows_reg = ACTIVE_ROWS_RESET;
            cols_reg = ACTIVE_COLUMNS_RESET;
            pending_results.delete();
            mismatches = 0;
            checked = 0;
            advances = 0;
            flagged = 0;
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (pending_results.size() == 0) begin
                    note_mismatch($sformatf("no item waiting, got cell_value %0d status %0d",
                                            i_res.cell_value, i_res.status));
                end else begin
                    wanted = pending_results.pop_front();
                    if (wanted.cell_value !== i_res.cell_value) begin
                        note_mismatch($sformatf("cell_value expected %0d, got %0d",
                                                wanted.cell_value, i_res.cell_value));
                    end
                    if (wanted.status !== i_res.status) begin
                        note_mismatch($sformatf("status expected %0d, got %0d",
                                                wanted.status, i_res.status));
                    end
                end
                checked++;
            end
            if (i_cmd.valid && i_cmd.ready) begin
                pending_results.push_back(apply_command(i_cmd.opcode, i_cmd.row_index,
                                                        i_cmd.column_index, i_cmd.write_value));
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_ACTIVE_ROWS) begin
                    rows_reg = i_cfg.data[6:0];
                end else if (i_cfg.index == REG_ACTIVE_COLUMNS) begin
                    cols_reg = i_cfg.data;
                end
            end
        end
        outstanding = pending_results.size();
    end

endmodule

FILE: tb/life_grid_generation_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// life_grid_generation_engine_unit_tb
// Drives the life grid engine with directed cell and grid commands at the
// default, smallest and largest active sizes, then random command streams at
// small, tall and wide sizes, with random gaps, result stalls and one long
// result hold-off. The grid predictor beside the block checks every result
// item.
module life_grid_generation_engine_unit_tb;
    import lgge_pkg::*;

    localparam int         MAX_ROWS        = 64;
    localparam int         MAX_COLUMNS     = 128;
    localparam t_opcode    OP_UNUSED_FIRST = 3'd5;
    localparam t_opcode    OP_UNUSED_LAST  = 3'd7;
    localparam t_cfg_index REG_SPARE_LOW   = 2'd2;
    localparam t_cfg_index REG_SPARE_HIGH  = 2'd3;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         PHASE_ITEMS     = 19;

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    bit   hold_request;
    int   rows_used;
    int   cols_used;
    int   reg_writes;
    int   holds_done;
    int   mismatches;
    int   outstanding;
    int   checked;
    int   advances;
    int   flagged;

    lgge_cmd_if cmd_bus ();
    lgge_res_if res_bus ();
    lgge_cfg_if cfg_bus ();

    life_grid_generation_engine_unit #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    lgge_grid_predictor #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) grid_predictor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_bus),
        .i_res         (res_bus),
        .i_cfg         (cfg_bus),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_advances    (advances),
        .o_flagged     (flagged)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("life_grid_generation_engine_unit_tb: FAIL");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                res_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
                holds_done++;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                res_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end else begin
                res_bus.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
        end
    end

    task automatic send_cmd(t_opcode op, t_row_index row, t_column_index col, t_cell wv);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.opcode       <= op;
        cmd_bus.row_index    <= row;
        cmd_bus.column_index <= col;
        cmd_bus.write_value  <= wv;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        cmd_bus.valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    task automatic cfg_write(t_cfg_index idx, t_cfg_data data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        reg_writes++;
    endtask

    task automatic set_grid(t_cfg_data rows_data, t_cfg_data cols_data);
        cfg_write(REG_ACTIVE_ROWS, rows_data);
        cfg_write(REG_ACTIVE_COLUMNS, cols_data);
        cfg_bus.valid <= 1'b0;
        rows_used = (rows_data[6:0] == 0) ? 1 :
                    (rows_data[6:0] > MAX_ROWS) ? MAX_ROWS : int'(rows_data[6:0]);
        cols_used = (cols_data == 0) ? 1 :
                    (cols_data > MAX_COLUMNS) ? MAX_COLUMNS : int'(cols_data);
    endtask

    task automatic random_cmd();
        int            pick;
        t_opcode       op;
        t_row_index    row;
        t_column_index col;
        t_cell         wv;
        pick = $urandom_range(0, 99);
        if (pick < 40)      op = OP_WRITE;
        else if (pick < 54) op = OP_TOGGLE;
        else if (pick < 78) op = OP_READ;
        else if (pick < 94) op = OP_ADVANCE;
        else if (pick < 96) op = OP_CLEAR;
        else                op = t_opcode'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        if ($urandom_range(0, 9) == 0) begin
            row = t_row_index'($urandom_range(0, MAX_ROWS - 1));
            col = t_column_index'($urandom_range(0, MAX_COLUMNS - 1));
        end else begin
            row = t_row_index'($urandom_range(0, rows_used - 1));
            col = t_column_index'($urandom_range(0, cols_used - 1));
        end
        wv = $urandom_range(0, 1) ? CELL_ALIVE : t_cell'($urandom_range(0, 3));
        send_cmd(op, row, col, wv);
    endtask

    task automatic run_random_phase(int count);
        repeat (count) random_cmd();
    endtask

    initial begin
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.opcode       = OP_READ;
        cmd_bus.row_index    = '0;
        cmd_bus.column_index = '0;
        cmd_bus.write_value  = CELL_EMPTY;
        res_bus.ready        = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = REG_ACTIVE_ROWS;
        cfg_bus.data         = '0;
        idle_on              = 1'b1;
        hold_request         = 1'b0;
        rows_used            = int'(ACTIVE_ROWS_RESET);
        cols_used            = int'(ACTIVE_COLUMNS_RESET);
        reg_writes           = 0;
        holds_done           = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default size: corners, write value three, toggles, range flags, unused codes, an advance and a clear
        send_cmd(OP_WRITE,  6'd0,  7'd0,  CELL_ALIVE);
        send_cmd(OP_WRITE,  6'd39, 7'd69, CELL_FORMER);
        send_cmd(OP_WRITE,  6'd0,  7'd69, CELL_UNUSED);
        send_cmd(OP_TOGGLE, 6'd0,  7'd0,  CELL_EMPTY);
        send_cmd(OP_TOGGLE, 6'd0,  7'd0,  CELL_EMPTY);
        send_cmd(OP_TOGGLE, 6'd39, 7'd69, CELL_EMPTY);
        send_cmd(OP_READ,   6'd39, 7'd69, CELL_EMPTY);
        send_cmd(OP_WRITE,  6'd40, 7'd0,  CELL_ALIVE);
        send_cmd(OP_READ,   6'd0,  7'd70, CELL_EMPTY);
        for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++) begin
            send_cmd(t_opcode'(op), 6'd63, 7'd127, CELL_UNUSED);
        end
        send_cmd(OP_WRITE,   6'd10, 7'd10, CELL_ALIVE);
        send_cmd(OP_WRITE,   6'd10, 7'd11, CELL_ALIVE);
        send_cmd(OP_WRITE,   6'd10, 7'd12, CELL_ALIVE);
        send_cmd(OP_ADVANCE, 6'd0,  7'd0,  CELL_EMPTY);
        send_cmd(OP_READ,    6'd9,  7'd11, CELL_EMPTY);
        send_cmd(OP_CLEAR,   6'd0,  7'd0,  CELL_EMPTY);
        send_cmd(OP_READ,    6'd9,  7'd11, CELL_EMPTY);

        // smallest size: zero saturates to one
        wait_idle();
        set_grid(8'd0, 8'd0);
        send_cmd(OP_WRITE,   6'd0, 7'd0, CELL_ALIVE);
        send_cmd(OP_ADVANCE, 6'd0, 7'd0, CELL_EMPTY);
        send_cmd(OP_READ,    6'd0, 7'd1, CELL_EMPTY);

        // largest size: oversized values saturate, spare indexes are dropped
        wait_idle();
        cfg_write(REG_SPARE_LOW, 8'd5);
        cfg_write(REG_SPARE_HIGH, 8'd9);
        set_grid(8'hC8, 8'hFF);
        send_cmd(OP_WRITE,   6'd63, 7'd127, CELL_ALIVE);
        send_cmd(OP_ADVANCE, 6'd0,  7'd0,   CELL_EMPTY);
        send_cmd(OP_READ,    6'd63, 7'd127, CELL_EMPTY);

        wait_idle();
        set_grid(t_cfg_data'($urandom_range(3, 8)), t_cfg_data'($urandom_range(3, 10)));
        hold_request = 1'b1;
        run_random_phase(PHASE_ITEMS);

        wait_idle();
        set_grid(8'd64, 8'd3);
        run_random_phase(PHASE_ITEMS);

        wait_idle();
        set_grid(8'd3, 8'd128);
        run_random_phase(PHASE_ITEMS);

        wait_idle();
        idle_on = 1'b0;
        set_grid(t_cfg_data'($urandom_range(3, 8)), t_cfg_data'($urandom_range(3, 10)));
        run_random_phase(PHASE_ITEMS);

        wait_idle();
        repeat (16) @(negedge i_clk);

        $display("%0d results checked, %0d advances, %0d out-of-range coordinates flagged",
                 checked, advances, flagged);
        $display("%0d register writes, sizes 1x1 to 64x128, %0d long result hold-offs",
                 reg_writes, holds_done);
        if (mismatches == 0 && outstanding == 0) begin
            $display("life_grid_generation_engine_unit_tb: PASS");
        end else begin
            $display("life_grid_generation_engine_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
